// ===== hw/rtl/jsu_pkg.sv =====
// jsu_pkg: types and constants shared by the json string unescaper
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // scanner mode
  typedef enum logic [3:0] {
    MODE_IDLE        = 4'd0,
    MODE_STR         = 4'd1,
    MODE_ESC         = 4'd2,
    MODE_HEX_FIRST   = 4'd3,
    MODE_NEED_BSLASH = 4'd4,
    MODE_NEED_U      = 4'd5,
    MODE_HEX_LOW     = 4'd6
  } mode_t;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [3:0] ERR_EXPECT_QUOTE = 4'd0;
  localparam logic [3:0] ERR_CONTROL      = 4'd1;
  localparam logic [3:0] ERR_UNTERM_ESC   = 4'd2;
  localparam logic [3:0] ERR_BAD_ESC      = 4'd3;
  localparam logic [3:0] ERR_SHORT_HEX    = 4'd4;
  localparam logic [3:0] ERR_BAD_HEX      = 4'd5;
  localparam logic [3:0] ERR_NO_LOW       = 4'd6;
  localparam logic [3:0] ERR_BAD_LOW      = 4'd7;
  localparam logic [3:0] ERR_UNTERM_STR   = 4'd8;

  // most result words one input byte can cause
  localparam int unsigned MAX_WORDS = 4;

  // scanner state; hex_value holds at most three collected digits
  typedef struct packed {
    mode_t       mode;
    logic [11:0] hex_value;
    logic [1:0]  hex_digits_seen;
    logic [9:0]  high_surrogate;
  } state_t;

  // one result word without its end-of-run mark
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [3:0] error_code;
  } result_t;

  typedef logic [2:0] word_count_t;

endpackage

`default_nettype wire

// ===== hw/rtl/jsu_in_if.sv =====
// jsu_in_if: input channel carrying raw text bytes and the end marker
`timescale 1ns / 1ps
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/jsu_out_if.sv =====
// jsu_out_if: output channel carrying decoded bytes, completion and errors
`timescale 1ns / 1ps
`default_nettype none

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [3:0] error_code;
  logic       last_of_run;

  modport source (output valid, output out_byte, output kind, output error_code,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input kind, input error_code,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/jsu_decode.sv =====
// jsu_decode: next-state and result words for one text byte
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode (
  input  jsu_pkg::state_t      st,
  input  logic [7:0]           in_byte,
  input  logic                 end_of_input,
  output jsu_pkg::state_t      st_next,
  output jsu_pkg::word_count_t res_count,
  output jsu_pkg::result_t     res_words [jsu_pkg::MAX_WORDS]
);
  import jsu_pkg::*;

  localparam logic [7:0]  CH_QUOTE  = 8'h22;
  localparam logic [7:0]  CH_BSLASH = 8'h5C;
  localparam logic [7:0]  CH_SLASH  = 8'h2F;
  localparam logic [7:0]  CH_SPACE  = 8'h20;
  localparam logic [7:0]  CH_U      = 8'h75;
  localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // hex digit value, bit 4 set when the byte is no hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) d = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      d = {1'b0, c[3:0] + 4'd9};
    return d;
  endfunction

  logic        err_hit;
  logic [3:0]  err_code;
  logic        enc_hit;
  logic [20:0] cp;
  logic [4:0]  digit;
  logic [15:0] hex_full;

  assign digit    = hex_digit(in_byte);
  assign hex_full = {st.hex_value, digit[3:0]};

  // mode sequencing
  always_comb begin
    st_next  = st;
    err_hit  = 1'b0;
    err_code = ERR_EXPECT_QUOTE;
    enc_hit  = 1'b0;
    cp       = '0;
    res_count = '0;
    for (int i = 0; i < MAX_WORDS; i++) res_words[i] = '0;

    unique case (st.mode)
      MODE_IDLE: begin
        if (end_of_input) begin
          err_hit = 1'b1;
        end else if (in_byte == CH_SPACE || (in_byte >= 8'h09 && in_byte <= 8'h0D)) begin
          st_next = st;
        end else if (in_byte == CH_QUOTE) begin
          st_next.mode = MODE_STR;
        end else begin
          err_hit = 1'b1;
        end
      end

      MODE_STR: begin
        if (end_of_input) begin
          err_hit  = 1'b1;
          err_code = ERR_UNTERM_STR;
        end else if (in_byte == CH_QUOTE) begin
          st_next      = '{mode: MODE_IDLE, default: '0};
          res_count    = 3'd1;
          res_words[0] = '{out_byte: 8'h00, kind: KIND_DONE, error_code: 4'd0};
        end else if (in_byte < CH_SPACE) begin
          err_hit  = 1'b1;
          err_code = ERR_CONTROL;
        end else if (in_byte == CH_BSLASH) begin
          st_next.mode = MODE_ESC;
        end else begin
          res_count    = 3'd1;
          res_words[0] = '{out_byte: in_byte, kind: KIND_DATA, error_code: 4'd0};
        end
      end

      MODE_ESC: begin
        if (end_of_input) begin
          err_hit  = 1'b1;
          err_code = ERR_UNTERM_ESC;
        end else begin
          st_next.mode = MODE_STR;
          res_count    = 3'd1;
          res_words[0].kind = KIND_DATA;
          unique case (in_byte)
            CH_QUOTE, CH_BSLASH, CH_SLASH: res_words[0].out_byte = in_byte;
            8'h62: res_words[0].out_byte = 8'h08;
            8'h66: res_words[0].out_byte = 8'h0C;
            8'h6E: res_words[0].out_byte = 8'h0A;
            8'h72: res_words[0].out_byte = 8'h0D;
            8'h74: res_words[0].out_byte = 8'h09;
            CH_U: begin
              res_count               = 3'd0;
              st_next.mode            = MODE_HEX_FIRST;
              st_next.hex_value       = '0;
              st_next.hex_digits_seen = '0;
            end
            default: begin
              err_hit  = 1'b1;
              err_code = ERR_BAD_ESC;
            end
          endcase
        end
      end

      MODE_HEX_FIRST, MODE_HEX_LOW: begin
        if (end_of_input) begin
          err_hit  = 1'b1;
          err_code = ERR_SHORT_HEX;
        end else if (digit[4]) begin
          err_hit  = 1'b1;
          err_code = ERR_BAD_HEX;
        end else if (st.hex_digits_seen != 2'd3) begin
          st_next.hex_value       = hex_full[11:0];
          st_next.hex_digits_seen = st.hex_digits_seen + 2'd1;
        end else begin
          st_next.hex_value       = '0;
          st_next.hex_digits_seen = '0;
          if (st.mode == MODE_HEX_FIRST) begin
            if (hex_full[15:10] == HIGH_SURR_TAG) begin
              st_next.high_surrogate = hex_full[9:0];
              st_next.mode           = MODE_NEED_BSLASH;
            end else begin
              st_next.mode = MODE_STR;
              enc_hit      = 1'b1;
              cp           = {5'd0, hex_full};
            end
          end else if (hex_full[15:10] != LOW_SURR_TAG) begin
            err_hit  = 1'b1;
            err_code = ERR_BAD_LOW;
          end else begin
            st_next.high_surrogate = '0;
            st_next.mode           = MODE_STR;
            enc_hit                = 1'b1;
            cp = SUPP_BASE + {1'b0, st.high_surrogate, hex_full[9:0]};
          end
        end
      end

      MODE_NEED_BSLASH: begin
        if (end_of_input || in_byte != CH_BSLASH) begin
          err_hit  = 1'b1;
          err_code = ERR_NO_LOW;
        end else begin
          st_next.mode = MODE_NEED_U;
        end
      end

      MODE_NEED_U: begin
        if (end_of_input || in_byte != CH_U) begin
          err_hit  = 1'b1;
          err_code = ERR_NO_LOW;
        end else begin
          st_next.mode            = MODE_HEX_LOW;
          st_next.hex_value       = '0;
          st_next.hex_digits_seen = '0;
        end
      end

      default: begin
        err_hit = 1'b1;
      end
    endcase

    // utf-8 encoding of a finished code point
    if (enc_hit) begin
      for (int i = 0; i < MAX_WORDS; i++) res_words[i].kind = KIND_DATA;
      priority if (cp <= 21'h7F) begin
        res_count = 3'd1;
        res_words[0].out_byte = {1'b0, cp[6:0]};
      end else if (cp <= 21'h7FF) begin
        res_count = 3'd2;
        res_words[0].out_byte = 8'hC0 | {3'd0, cp[10:6]};
        res_words[1].out_byte = 8'h80 | {2'd0, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
        res_count = 3'd3;
        res_words[0].out_byte = 8'hE0 | {4'd0, cp[15:12]};
        res_words[1].out_byte = 8'h80 | {2'd0, cp[11:6]};
        res_words[2].out_byte = 8'h80 | {2'd0, cp[5:0]};
      end else begin
        res_count = 3'd4;
        res_words[0].out_byte = 8'hF0 | {5'd0, cp[20:18]};
        res_words[1].out_byte = 8'h80 | {2'd0, cp[17:12]};
        res_words[2].out_byte = 8'h80 | {2'd0, cp[11:6]};
        res_words[3].out_byte = 8'h80 | {2'd0, cp[5:0]};
      end
    end

    // any error clears the work state and returns to idle
    if (err_hit) begin
      st_next      = '{mode: MODE_IDLE, default: '0};
      res_count    = 3'd1;
      for (int i = 0; i < MAX_WORDS; i++) res_words[i] = '0;
      res_words[0] = '{out_byte: 8'h00, kind: KIND_ERR, error_code: err_code};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/json_string_unescape_utf8.sv =====
// json_string_unescape_utf8: top level of the json string unescaper
`timescale 1ns / 1ps
`default_nettype none

// Scans JSON text one byte per word and emits the unescaped string contents
// as UTF-8 data words, followed by a completion word at the closing quote, or
// a single error word, after which the scanner is idle again. Each input word
// is registered, decoded combinationally against the scanner state and loaded
// into a four-word result slot that drains through the output port one word
// per cycle while the output is ready; the last word caused by an input
// carries last_of_run. A byte that gives at most one result word is taken
// every cycle while the output is ready; a code point that leaves as n
// UTF-8 bytes occupies the result slot, and so the input path, until all n
// have left.
module json_string_unescape_utf8 (
  input  wire      clk,
  input  wire      rst,
  jsu_in_if.sink   in_ch,
  jsu_out_if.source out_ch
);
  import jsu_pkg::*;

  // input register
  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_end;

  // scanner state
  state_t st;
  state_t st_next;

  // result slot
  result_t     slot_words [MAX_WORDS];
  word_count_t slot_cnt;
  logic [1:0]  slot_pos;

  word_count_t dec_count;
  result_t     dec_words [MAX_WORDS];

  logic slot_busy;
  logic slot_last;
  logic out_fire;
  logic slot_done;
  logic load;
  logic in_fire;

  jsu_decode u_decode (
    .st           (st),
    .in_byte      (in_q_byte),
    .end_of_input (in_q_end),
    .st_next      (st_next),
    .res_count    (dec_count),
    .res_words    (dec_words)
  );

  // handshake control
  assign slot_busy = (slot_cnt != 3'd0);
  assign slot_last = ({1'b0, slot_pos} == slot_cnt - 3'd1);
  assign out_fire  = slot_busy && out_ch.ready;
  assign slot_done = out_fire && slot_last;
  assign load      = in_q_valid && (!slot_busy || slot_done);
  assign in_ch.ready = !in_q_valid || load;
  assign in_fire   = in_ch.valid && in_ch.ready;

  // output drive
  assign out_ch.valid       = slot_busy;
  assign out_ch.out_byte    = slot_words[slot_pos].out_byte;
  assign out_ch.kind        = slot_words[slot_pos].kind;
  assign out_ch.error_code  = slot_words[slot_pos].error_code;
  assign out_ch.last_of_run = slot_last;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_fire) begin
      in_q_valid <= 1'b1;
    end else if (load) begin
      in_q_valid <= 1'b0;
    end
    if (in_fire) begin
      in_q_byte <= in_ch.in_byte;
      in_q_end  <= in_ch.end_of_input;
    end
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{mode: MODE_IDLE, default: '0};
    end else if (load) begin
      st <= st_next;
    end
  end

  // result slot control
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_cnt <= '0;
      slot_pos <= '0;
    end else if (load && dec_count != 3'd0) begin
      slot_cnt <= dec_count;
      slot_pos <= '0;
    end else if (slot_done) begin
      slot_cnt <= '0;
      slot_pos <= '0;
    end else if (out_fire) begin
      slot_pos <= slot_pos + 2'd1;
    end
  end

  // result slot words
  always_ff @(posedge clk) begin
    if (load && dec_count != 3'd0) begin
      for (int i = 0; i < MAX_WORDS; i++) slot_words[i] <= dec_words[i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_checker.sv =====
// jsu_checker: port-level checks on the json string unescaper, with its bind
`timescale 1ns / 1ps
`default_nettype none

module jsu_checker (
  input wire       clk,
  input wire       rst,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_byte,
  input wire [1:0] kind,
  input wire [3:0] error_code,
  input wire       last_of_run
);
  import jsu_pkg::*;

  // completion and error words close their run
  a_ctrl_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> last_of_run)
    else $error("completion or error word not marked last of run");

  // only data words carry a byte
  a_ctrl_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> out_byte == 8'h00)
    else $error("non-data word carries a byte");

  // error code only on error words, and within range
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_ERR) ? (error_code <= ERR_UNTERM_STR) : (error_code == 4'd0))
    else $error("error code out of place");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
      && $stable(error_code) && $stable(last_of_run))
    else $error("stalled output word changed");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .kind        (out_ch.kind),
  .error_code  (out_ch.error_code),
  .last_of_run (out_ch.last_of_run)
);

`default_nettype wire
